// ===== hw/rtl/ptw_pkg.sv =====
// ptw_pkg: shared constants, codes and control types of the page table walker
// used by every module under hw/rtl; depends on nothing
package ptw_pkg;

  localparam int unsigned TABLE_PAGES       = 16;
  localparam int unsigned ENTRIES_PER_TABLE = 512;
  localparam int unsigned IDX_W             = $clog2(ENTRIES_PER_TABLE);
  localparam int unsigned PAGE_W            = $clog2(TABLE_PAGES);
  localparam int unsigned DEPTH             = TABLE_PAGES * ENTRIES_PER_TABLE;
  localparam int unsigned ADDR_W            = PAGE_W + IDX_W;

  localparam int unsigned ENTRY_W     = 64;
  localparam int unsigned VPN_W       = 36;
  localparam int unsigned FRAME_W     = 40;
  localparam int unsigned PAGE_NUM_W  = 4;
  localparam int unsigned PRESENT_BIT = 0;
  localparam int unsigned SIZE_BIT    = 7;
  localparam int unsigned FRAME_LSB   = 12;
  localparam int unsigned SHIFT_1G    = 18;
  localparam int unsigned SHIFT_2M    = 9;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_ROOT_ADDR = 3'd0;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_XLATE = 1'b1;

  localparam logic [1:0] SIZE_NONE = 2'd0;
  localparam logic [1:0] SIZE_4K   = 2'd1;
  localparam logic [1:0] SIZE_2M   = 2'd2;
  localparam logic [1:0] SIZE_1G   = 2'd3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK
  } state_e;

  typedef enum logic [1:0] {
    LVL_1,
    LVL_2,
    LVL_3,
    LVL_4
  } level_e;

  typedef struct packed {
    logic clear;
    logic write;
    logic start;
    logic step;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic walk_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== hw/rtl/ptw_datapath.sv =====
// ptw_datapath: table store memory, walk registers, level decode and result register
// depends on ptw_pkg; driven by ptw_ctrl through ctrl_cmd_t / ctrl_sts_t
module ptw_datapath import ptw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_cmd_t             cmd_i,
  output ctrl_sts_t             sts_o,
  input  logic [PAGE_NUM_W-1:0] entry_page_i,
  input  logic [IDX_W-1:0]      entry_index_i,
  input  logic [ENTRY_W-1:0]    entry_value_i,
  input  logic [VPN_W-1:0]      virtual_page_i,
  input  logic [PAGE_NUM_W-1:0] root_page_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [FRAME_W-1:0]    page_frame_o,
  output logic [1:0]            size_code_o,
  output logic [PAGE_NUM_W-1:0] last_table_page_o,
  output logic                  fault_o
);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_q;

  logic [ADDR_W-1:0]  clr_addr_q, clr_addr_d;
  logic [ADDR_W-1:0]  mem_addr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_we, mem_re;

  logic [VPN_W-1:0]  vp_q;
  logic [PAGE_W-1:0] tbl_q;
  level_e            lvl_q, lvl_d;
  logic              root_flt_q, root_flt_d;

  logic [FRAME_W-1:0] wr_page_ext, root_ext, tbl_ext, frame;
  logic               wr_ok, frame_bad, present, leaf;
  logic [IDX_W-1:0]   next_idx;

  logic [FRAME_W-1:0]    res_frame;
  logic [1:0]            res_size;
  logic [PAGE_NUM_W-1:0] res_page;
  logic                  res_fault, walk_done;

  logic                  out_valid_q;
  logic [FRAME_W-1:0]    page_frame_q;
  logic [1:0]            size_code_q;
  logic [PAGE_NUM_W-1:0] last_page_q;
  logic                  fault_q;

  assign wr_page_ext = FRAME_W'(entry_page_i);
  assign root_ext    = FRAME_W'(root_page_i);
  assign tbl_ext     = FRAME_W'(tbl_q);
  assign wr_ok       = wr_page_ext < FRAME_W'(TABLE_PAGES);
  assign frame       = rdata_q[FRAME_LSB +: FRAME_W];
  assign frame_bad   = frame >= FRAME_W'(TABLE_PAGES);
  assign present     = rdata_q[PRESENT_BIT];
  assign leaf        = rdata_q[SIZE_BIT];

  always_comb begin
    case (lvl_q)
      LVL_4:   next_idx = vp_q[2*IDX_W +: IDX_W];
      LVL_3:   next_idx = vp_q[IDX_W +: IDX_W];
      default: next_idx = vp_q[0 +: IDX_W];
    endcase
  end

  // memory port select
  always_comb begin
    mem_addr  = {frame[PAGE_W-1:0], next_idx};
    mem_wdata = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    if (cmd_i.clear) begin
      mem_addr = clr_addr_q;
      mem_we   = 1'b1;
    end else if (cmd_i.write) begin
      mem_addr  = {wr_page_ext[PAGE_W-1:0], entry_index_i};
      mem_wdata = entry_value_i;
      mem_we    = wr_ok;
    end else if (cmd_i.start) begin
      mem_addr = {root_ext[PAGE_W-1:0], virtual_page_i[3*IDX_W +: IDX_W]};
      mem_re   = 1'b1;
    end else if (cmd_i.step) begin
      mem_re = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  // decode of the entry read at the current level
  always_comb begin
    res_frame = '0;
    res_size  = SIZE_NONE;
    res_page  = '0;
    res_fault = 1'b0;
    walk_done = 1'b1;
    if (lvl_q == LVL_4 && root_flt_q) begin
      res_fault = 1'b1;
    end else if (!present) begin
      if (lvl_q == LVL_1) begin
        res_page = tbl_ext[PAGE_NUM_W-1:0];
      end
    end else if (lvl_q == LVL_1) begin
      res_frame = frame;
      res_size  = SIZE_4K;
      res_page  = tbl_ext[PAGE_NUM_W-1:0];
    end else if (lvl_q == LVL_3 && leaf) begin
      res_frame = frame >> SHIFT_1G;
      res_size  = SIZE_1G;
    end else if (lvl_q == LVL_2 && leaf) begin
      res_frame = frame >> SHIFT_2M;
      res_size  = SIZE_2M;
    end else if (frame_bad) begin
      res_fault = 1'b1;
    end else begin
      walk_done = 1'b0;
    end
  end

  always_comb begin
    clr_addr_d = clr_addr_q;
    lvl_d      = lvl_q;
    root_flt_d = root_flt_q;
    if (cmd_i.clear) begin
      clr_addr_d = clr_addr_q + ADDR_W'(1);
    end
    if (cmd_i.start) begin
      lvl_d      = LVL_4;
      root_flt_d = root_ext >= FRAME_W'(TABLE_PAGES);
    end else if (cmd_i.step) begin
      lvl_d = level_e'(lvl_q - 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      lvl_q       <= LVL_4;
      root_flt_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_addr_q <= clr_addr_d;
      lvl_q      <= lvl_d;
      root_flt_q <= root_flt_d;
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      vp_q <= virtual_page_i;
    end
    if (cmd_i.step) begin
      tbl_q <= frame[PAGE_W-1:0];
    end
    if (cmd_i.load) begin
      page_frame_q <= res_frame;
      size_code_q  <= res_size;
      last_page_q  <= res_page;
      fault_q      <= res_fault;
    end
  end

  assign sts_o.clr_last  = clr_addr_q == ADDR_W'(DEPTH - 1);
  assign sts_o.walk_done = walk_done;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign page_frame_o      = page_frame_q;
  assign size_code_o       = size_code_q;
  assign last_table_page_o = last_page_q;
  assign fault_o           = fault_q;

endmodule

// ===== hw/rtl/ptw_ctrl.sv =====
// ptw_ctrl: state machine that sequences store clearing, entry writes and table walks
// depends on ptw_pkg; drives ptw_datapath through ctrl_cmd_t / ctrl_sts_t
module ptw_ctrl import ptw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      kind_i,
  output logic      in_ready_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (kind_i == KIND_XLATE) begin
            cmd_o.start = 1'b1;
            state_d     = ST_WALK;
          end else begin
            cmd_o.write = 1'b1;
          end
        end
      end
      ST_WALK: begin
        if (sts_i.walk_done) begin
          if (sts_i.out_free) begin
            cmd_o.load = 1'b1;
            state_d    = ST_IDLE;
          end
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== hw/rtl/four_level_page_table_walker_core.sv =====
// four_level_page_table_walker_core: top level with the root register port
// depends on ptw_pkg, ptw_ctrl and ptw_datapath
//
// usage
//   input channel (in_valid_i / in_ready_o) takes write items (kind 0) that load
//   one 64-bit entry, and translate items (kind 1) that walk the four levels
//   output channel (out_valid_o / out_ready_i) carries one result per translate
//   root_table_page sits at byte address 0 of the apb-style port, 4 bits wide
// timing
//   a write goes straight into the table memory; writes can be sent in every cycle while idle
//   a translate reads one table entry per level, from the root level down, through
//   the registered read of the single-port table memory until the walk resolves
//   the next item is taken in the cycle after the result is registered
// reset
//   the table memory is cleared one entry a cycle, all TABLE_PAGES * 512 entries
//   (8192 as built); in_ready_o stays low during that pass
// stall
//   a result waits in the output register; the next translate may start and
//   holds at its last level until that register is free
module four_level_page_table_walker_core import ptw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  kind_i,
  input  logic [PAGE_NUM_W-1:0] entry_page_i,
  input  logic [IDX_W-1:0]      entry_index_i,
  input  logic [ENTRY_W-1:0]    entry_value_i,
  input  logic [VPN_W-1:0]      virtual_page_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [FRAME_W-1:0]    page_frame_o,
  output logic [1:0]            size_code_o,
  output logic [PAGE_NUM_W-1:0] last_table_page_o,
  output logic                  fault_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [PAGE_NUM_W-1:0] root_q, root_d;
  logic                  cfg_wr;
  ctrl_cmd_t             cmd;
  ctrl_sts_t             sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    root_d = root_q;
    if (cfg_wr && paddr == REG_ROOT_ADDR) begin
      root_d = pwdata[PAGE_NUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else begin
      root_q <= root_d;
    end
  end

  assign prdata = (paddr == REG_ROOT_ADDR) ? CFG_DATA_W'(root_q) : '0;

  ptw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ptw_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .entry_page_i      (entry_page_i),
    .entry_index_i     (entry_index_i),
    .entry_value_i     (entry_value_i),
    .virtual_page_i    (virtual_page_i),
    .root_page_i       (root_q),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .page_frame_o      (page_frame_o),
    .size_code_o       (size_code_o),
    .last_table_page_o (last_table_page_o),
    .fault_o           (fault_o)
  );

endmodule

// ===== hw/rtl/ptw_checker.sv =====
// ptw_checker: port-level assertions on the walker top level, attached by bind
// depends on ptw_pkg and four_level_page_table_walker_core
module ptw_checker import ptw_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  kind_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [FRAME_W-1:0]    page_frame_o,
  input logic [1:0]            size_code_o,
  input logic [PAGE_NUM_W-1:0] last_table_page_o,
  input logic                  fault_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(page_frame_o) && $stable(size_code_o) &&
      $stable(last_table_page_o) && $stable(fault_o))
    else $error("result changed while stalled");

  a_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i == KIND_XLATE |=> !in_ready_o)
    else $error("input taken during a walk");

  a_fault_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fault_o |->
      page_frame_o == '0 && size_code_o == SIZE_NONE && last_table_page_o == '0)
    else $error("fault result carries a mapping");

  a_large_no_pt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (size_code_o == SIZE_2M || size_code_o == SIZE_1G) |->
      last_table_page_o == '0)
    else $error("large page reports a page table");

endmodule

bind four_level_page_table_walker_core ptw_checker u_ptw_checker (.*);

// ===== tb/four_level_page_table_walker_core_tb.sv =====
`timescale 1ns / 100ps
// four_level_page_table_walker_core_tb: self-checking bench for the page table walker core
// mirrors the table store and root register, predicts each translate and checks every result
// depends on ptw_pkg and four_level_page_table_walker_core
module four_level_page_table_walker_core_tb;
  import ptw_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 300000;
  localparam int unsigned LONG_HOLD_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_ADDR = 3'd4;

  typedef struct packed {
    logic [FRAME_W-1:0]    page_frame;
    logic [1:0]            size_code;
    logic [PAGE_NUM_W-1:0] last_table_page;
    logic                  fault;
  } walk_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  kind_i = KIND_WRITE;
  logic [PAGE_NUM_W-1:0] entry_page_i = '0;
  logic [IDX_W-1:0]      entry_index_i = '0;
  logic [ENTRY_W-1:0]    entry_value_i = '0;
  logic [VPN_W-1:0]      virtual_page_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [FRAME_W-1:0]    page_frame_o;
  logic [1:0]            size_code_o;
  logic [PAGE_NUM_W-1:0] last_table_page_o;
  logic                  fault_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic [ENTRY_W-1:0]    table_mirror [DEPTH];
  logic [PAGE_NUM_W-1:0] root_page;
  walk_result_t          pending_translations [$];

  bit          idle_on = 1'b1;
  bit          long_hold_pending = 1'b0;
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned size_tally [4] = '{0, 0, 0, 0};
  int unsigned fault_tally = 0;
  int unsigned cycle_count;

  four_level_page_table_walker_core u_top (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ENTRY_W-1:0] entry_word(logic present, logic leaf,
                                                    logic [FRAME_W-1:0] frame);
    logic [ENTRY_W-1:0] e;
    e = rand64();
    e[FRAME_LSB +: FRAME_W] = frame;
    e[PRESENT_BIT] = present;
    e[SIZE_BIT] = leaf;
    return e;
  endfunction

  // any frame at or beyond the end of the store
  function automatic logic [FRAME_W-1:0] out_of_store_frame();
    logic [FRAME_W-1:0] f;
    f = FRAME_W'(rand64());
    f[$urandom_range(PAGE_NUM_W, FRAME_W - 1)] = 1'b1;
    return f;
  endfunction

  function automatic walk_result_t translate_walk(logic [VPN_W-1:0] vp);
    walk_result_t r;
    logic [ENTRY_W-1:0] e;
    logic [FRAME_W-1:0] frame;
    int unsigned page;
    r = '0;
    page = root_page;
    for (int l = LVL_4; l >= LVL_1; l--) begin
      e = table_mirror[page * ENTRIES_PER_TABLE + vp[l*IDX_W +: IDX_W]];
      frame = e[FRAME_LSB +: FRAME_W];
      if (!e[PRESENT_BIT]) begin
        if (l == LVL_1) r.last_table_page = PAGE_NUM_W'(page);
        return r;
      end
      if (l == LVL_1) begin
        r.page_frame = frame;
        r.size_code = SIZE_4K;
        r.last_table_page = PAGE_NUM_W'(page);
        return r;
      end
      // size bit only counts at levels 3 and 2
      if (e[SIZE_BIT] && l != LVL_4) begin
        r.page_frame = (l == LVL_3) ? frame >> SHIFT_1G : frame >> SHIFT_2M;
        r.size_code = (l == LVL_3) ? SIZE_1G : SIZE_2M;
        return r;
      end
      if (frame >= TABLE_PAGES) begin
        r.fault = 1'b1;
        return r;
      end
      page = frame[PAGE_NUM_W-1:0];
    end
    return r;
  endfunction

  task automatic send_item(input logic kind, input logic [PAGE_NUM_W-1:0] page,
                           input logic [IDX_W-1:0] index, input logic [ENTRY_W-1:0] value,
                           input logic [VPN_W-1:0] vp);
    walk_result_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    entry_page_i   <= page;
    entry_index_i  <= index;
    entry_value_i  <= value;
    virtual_page_i <= vp;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (kind == KIND_WRITE) begin
      table_mirror[page * ENTRIES_PER_TABLE + index] = value;
    end else begin
      r = translate_walk(vp);
      pending_translations.push_back(r);
      size_tally[r.size_code]++;
      if (r.fault) fault_tally++;
    end
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_translations.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic write, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    if (write && addr == REG_ROOT_ADDR) root_page = wdata[PAGE_NUM_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_root_readback();
    logic [CFG_DATA_W-1:0] rd;
    apb_access(1'b0, REG_ROOT_ADDR, '0, rd);
    if (rd !== CFG_DATA_W'(root_page)) begin
      $error("root_table_page: expected %h, got %h", CFG_DATA_W'(root_page), rd);
      error_count++;
    end
  endtask

  task automatic program_root(input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] rd;
    wait_for_results();
    apb_access(1'b1, REG_ROOT_ADDR, value, rd);
    check_root_readback();
  endtask

  // builds a path from the root down to a chosen level, then translates through it
  task automatic run_mapped_walk();
    logic [VPN_W-1:0]   vp;
    logic [ENTRY_W-1:0] e;
    int unsigned        page, next_page, pick;
    int                 stop_level;
    vp = VPN_W'(rand64());
    stop_level = $urandom_range(LVL_1, LVL_4);
    page = root_page;
    for (int l = LVL_4; l >= stop_level; l--) begin
      pick = $urandom_range(0, 99);
      next_page = $urandom_range(0, TABLE_PAGES - 1);
      if (l > stop_level)
        e = entry_word(1'b1, (l == LVL_4) ? pick[0] : 1'b0, FRAME_W'(next_page));
      else if (l == LVL_1)
        e = entry_word(pick >= 15, pick[0], FRAME_W'(rand64()));
      else if (l == LVL_4)
        e = entry_word(pick >= 40, pick[0], out_of_store_frame());
      else if (pick < 15)
        e = entry_word(1'b0, pick[0], FRAME_W'(rand64()));
      else if (pick < 40)
        e = entry_word(1'b1, 1'b0, out_of_store_frame());
      else
        e = entry_word(1'b1, 1'b1, FRAME_W'(rand64()));
      send_item(KIND_WRITE, PAGE_NUM_W'(page), vp[l*IDX_W +: IDX_W], e, VPN_W'(rand64()));
      page = next_page;
    end
    send_item(KIND_XLATE, PAGE_NUM_W'(rand64()), IDX_W'(rand64()), rand64(), vp);
    // neighbor page in the same level-1 table
    if ($urandom_range(0, 1) == 1)
      send_item(KIND_XLATE, PAGE_NUM_W'(rand64()), IDX_W'(rand64()), rand64(),
                vp ^ VPN_W'($urandom_range(1, ENTRIES_PER_TABLE - 1)));
  endtask

  task automatic test_directed();
    send_item(KIND_XLATE, '0, '0, '0, '0);
    send_item(KIND_XLATE, '1, '1, '1, '1);
    send_item(KIND_WRITE, 4'd0, 9'd0, entry_word(1'b1, 1'b1, FRAME_W'(1)), '0);
    send_item(KIND_WRITE, 4'd1, 9'd0, entry_word(1'b1, 1'b1, '1), '0);
    send_item(KIND_XLATE, '0, '0, '0, {9'd0, 9'd0, 9'd0, 9'd0});
    send_item(KIND_WRITE, 4'd1, 9'd1, entry_word(1'b1, 1'b0, FRAME_W'(2)), '0);
    send_item(KIND_WRITE, 4'd2, 9'd0, entry_word(1'b1, 1'b1, FRAME_W'(rand64())), '0);
    send_item(KIND_XLATE, '0, '0, '0, {9'd0, 9'd1, 9'd0, 9'd0});
    send_item(KIND_WRITE, 4'd2, 9'd511, entry_word(1'b1, 1'b0, FRAME_W'(15)), '0);
    send_item(KIND_WRITE, 4'd15, 9'd511, entry_word(1'b1, 1'b1, '1), '0);
    send_item(KIND_XLATE, '0, '0, '0, {9'd0, 9'd1, 9'd511, 9'd511});
    send_item(KIND_XLATE, '0, '0, '0, {9'd0, 9'd1, 9'd511, 9'd0});
    send_item(KIND_WRITE, 4'd2, 9'd5, entry_word(1'b1, 1'b0, FRAME_W'(TABLE_PAGES)), '0);
    send_item(KIND_XLATE, '0, '0, '0, {9'd0, 9'd1, 9'd5, 9'd0});
    send_item(KIND_WRITE, 4'd1, 9'd2, entry_word(1'b1, 1'b0, '1), '0);
    send_item(KIND_XLATE, '0, '0, '0, {9'd0, 9'd2, 9'd0, 9'd0});
    send_item(KIND_WRITE, 4'd0, 9'd511, '0, '0);
    send_item(KIND_XLATE, '0, '0, '0, {9'd511, 9'd0, 9'd0, 9'd0});
    send_item(KIND_WRITE, 4'd0, 9'd511, entry_word(1'b1, 1'b0, '1), '0);
    send_item(KIND_XLATE, '0, '0, '0, {9'd511, 9'd0, 9'd0, 9'd0});
    send_item(KIND_WRITE, 4'd1, 9'd3, '1, '0);
    send_item(KIND_XLATE, '0, '0, '0, {9'd0, 9'd3, 9'd0, 9'd0});
  endtask

  task automatic test_root_register();
    logic [CFG_DATA_W-1:0] rd;
    program_root(32'd15);
    apb_access(1'b1, REG_UNUSED_ADDR, '1, rd);
    check_root_readback();
    send_item(KIND_XLATE, '0, '0, '0, {9'd511, 9'd0, 9'd0, 9'd0});
    send_item(KIND_XLATE, '0, '0, '0, '0);
    program_root(32'hFFFF_FFF0);
  endtask

  task automatic test_random_walks(input int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1: send_item(KIND_WRITE, PAGE_NUM_W'(rand64()), IDX_W'(rand64()), rand64(),
                        VPN_W'(rand64()));
        2: send_item(KIND_XLATE, PAGE_NUM_W'(rand64()), IDX_W'(rand64()), rand64(),
                     VPN_W'(rand64()));
        default: run_mapped_walk();
      endcase
    end
  endtask

  task automatic test_backpressure();
    long_hold_pending = 1'b1;
    test_random_walks(40);
    wait_for_results();
  endtask

  // result side: random stall bursts plus one long hold on request
  initial begin : result_sink
    int n;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        n = $urandom_range(1, 8);
        repeat (n) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    walk_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_translations.size() == 0) begin
        $error("result transfer with no translate outstanding: page_frame %h", page_frame_o);
        error_count++;
      end else begin
        want = pending_translations.pop_front();
        results_checked++;
        if (page_frame_o !== want.page_frame) begin
          $error("page_frame: expected %h, got %h", want.page_frame, page_frame_o);
          error_count++;
        end
        if (size_code_o !== want.size_code) begin
          $error("size_code: expected %0d, got %0d", want.size_code, size_code_o);
          error_count++;
        end
        if (last_table_page_o !== want.last_table_page) begin
          $error("last_table_page: expected %0d, got %0d", want.last_table_page,
                 last_table_page_o);
          error_count++;
        end
        if (fault_o !== want.fault) begin
          $error("fault: expected %0d, got %0d", want.fault, fault_o);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_translations.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [CFG_DATA_W-1:0] rd;
    foreach (table_mirror[i]) table_mirror[i] = '0;
    root_page = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_access(1'b1, REG_ROOT_ADDR, '0, rd);
    check_root_readback();

    test_directed();
    test_root_register();
    program_root(CFG_DATA_W'($urandom_range(1, TABLE_PAGES - 2)));
    test_random_walks(220);
    program_root(32'd15);
    test_random_walks(220);
    program_root(32'd0);
    test_random_walks(220);
    program_root(CFG_DATA_W'($urandom));
    test_random_walks(220);
    test_backpressure();
    idle_on = 1'b0;
    test_random_walks(150);
    wait_for_results();

    $display("%0d items, %0d translations checked: %0d no page, %0d 4K, %0d 2M, %0d 1G",
             items_sent, results_checked, size_tally[SIZE_NONE], size_tally[SIZE_4K],
             size_tally[SIZE_2M], size_tally[SIZE_1G]);
    $display("%0d faults; root pages 0, 15 and random; long output stall and drains",
             fault_tally);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== four_level_page_table_walker_core.f =====
hw/rtl/ptw_pkg.sv
hw/rtl/ptw_datapath.sv
hw/rtl/ptw_ctrl.sv
hw/rtl/four_level_page_table_walker_core.sv
hw/rtl/ptw_checker.sv
tb/four_level_page_table_walker_core_tb.sv
